>>> hw/rtl/lsr_pkg.sv
// ----------------------------------------------------------------------------
// Link supervisor package
// Shared types, codes and reset values for the link supervisor.
// ----------------------------------------------------------------------------
package lsr_pkg;

    localparam int unsigned TimeW  = 32;
    localparam int unsigned CfgW   = 16;
    localparam int unsigned AddrW  = 4;
    localparam int unsigned DataW  = 32;

    typedef enum logic [2:0] {
        ST_OFFLINE = 3'b001,
        ST_RECONN  = 3'b010,
        ST_ONLINE  = 3'b100
    } t_state;

    typedef logic [1:0] t_event;
    typedef logic [1:0] t_mode_code;
    typedef logic [1:0] t_reg_idx;

    localparam t_event EV_NONE     = 2'd0;
    localparam t_event EV_OFFLINE  = 2'd1;
    localparam t_event EV_ONLINE   = 2'd2;
    localparam t_event EV_RECOVERY = 2'd3;

    localparam t_mode_code MODE_OFFLINE = 2'd0;
    localparam t_mode_code MODE_RECONN  = 2'd1;
    localparam t_mode_code MODE_ONLINE  = 2'd2;

    localparam t_reg_idx REG_RECONNECT_DELAY = 2'd0;
    localparam t_reg_idx REG_BLINK_PERIOD    = 2'd1;
    localparam t_reg_idx REG_RECOVERY_WINDOW = 2'd2;

    localparam logic [CfgW-1:0] RST_RECONNECT_DELAY = 16'd5000;
    localparam logic [CfgW-1:0] RST_BLINK_PERIOD    = 16'd1000;
    localparam logic [CfgW-1:0] RST_RECOVERY_WINDOW = 16'd5000;

endpackage

>>> hw/rtl/lsr_intf.sv
// ----------------------------------------------------------------------------
// Link supervisor channels
// Poll channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lsr_poll_if;
    logic                        valid;
    logic                        ready;
    logic [lsr_pkg::TimeW-1:0]   now_ms;
    logic                        default_iface_present;
    logic                        interface_up;
    logic                        link_up;
    logic                        address_set;

    modport source (
        output valid, now_ms, default_iface_present, interface_up, link_up,
               address_set,
        input  ready
    );
    modport sink (
        input  valid, now_ms, default_iface_present, interface_up, link_up,
               address_set,
        output ready
    );
endinterface

interface lsr_result_if;
    logic                   valid;
    logic                   ready;
    logic                   indicator_on;
    logic                   phy_reset_pulse;
    lsr_pkg::t_event        event_code;
    logic [3:0]             status_flags;
    lsr_pkg::t_mode_code    link_mode;

    modport source (
        output valid, indicator_on, phy_reset_pulse, event_code, status_flags,
               link_mode,
        input  ready
    );
    modport sink (
        input  valid, indicator_on, phy_reset_pulse, event_code, status_flags,
               link_mode,
        output ready
    );
endinterface

>>> hw/rtl/link_supervisor_with_recovery.sv
// ----------------------------------------------------------------------------
// Link supervisor with recovery
// A poll transfer yields its result in the cycle after it is accepted.
// Throughput: one poll per cycle while results are taken; the result register frees as it is taken.
// The state update and all three elapsed-time compares are combinational.
// Synchronous active-low reset: mode offline, stamps and blink level zero,
// delay 5000, blink period 1000, recovery window 5000, result register empty.
// ----------------------------------------------------------------------------
module link_supervisor_with_recovery (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    lsr_poll_if.sink                      i_poll,
    lsr_result_if.source                  o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lsr_pkg::AddrW-1:0]     paddr,
    input  logic [lsr_pkg::DataW-1:0]     pwdata,
    output logic [lsr_pkg::DataW-1:0]     prdata,
    output logic                          pready
);

    logic [lsr_pkg::CfgW-1:0]  r_delay, r_period, r_window;
    lsr_pkg::t_state           r_state, n_state;
    logic [lsr_pkg::TimeW-1:0] r_entry, n_entry;
    logic [lsr_pkg::TimeW-1:0] r_blink, n_blink;
    logic                      r_level, n_level;

    logic                      r_out_valid;
    logic                      r_led, n_led;
    logic                      r_pulse, n_pulse;
    lsr_pkg::t_event           r_event, n_event;
    logic [3:0]                r_flags;
    lsr_pkg::t_mode_code       r_mode_out, n_mode_out;

    logic                      w_accept;
    logic                      w_cfg_wr;
    lsr_pkg::t_reg_idx         w_idx;
    logic                      w_ready_link;
    logic [lsr_pkg::TimeW-1:0] w_el_entry, w_el_blink;
    logic                      w_delay_done, w_blink_due, w_window_done;
    logic                      w_lvl;

    assign pready   = 1'b1;
    assign w_idx    = paddr[3:2];
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        case (w_idx)
            lsr_pkg::REG_RECONNECT_DELAY: prdata = {16'd0, r_delay};
            lsr_pkg::REG_BLINK_PERIOD:    prdata = {16'd0, r_period};
            lsr_pkg::REG_RECOVERY_WINDOW: prdata = {16'd0, r_window};
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay  <= lsr_pkg::RST_RECONNECT_DELAY;
            r_period <= lsr_pkg::RST_BLINK_PERIOD;
            r_window <= lsr_pkg::RST_RECOVERY_WINDOW;
        end else if (w_cfg_wr) begin
            case (w_idx)
                lsr_pkg::REG_RECONNECT_DELAY: r_delay  <= pwdata[15:0];
                lsr_pkg::REG_BLINK_PERIOD:    r_period <= pwdata[15:0];
                lsr_pkg::REG_RECOVERY_WINDOW: r_window <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    assign i_poll.ready = !r_out_valid || o_result.ready;
    assign w_accept     = i_poll.valid && i_poll.ready;

    assign w_ready_link  = i_poll.interface_up && i_poll.link_up && i_poll.address_set;
    assign w_el_entry    = i_poll.now_ms - r_entry;
    assign w_el_blink    = i_poll.now_ms - r_blink;
    assign w_delay_done  = w_el_entry >= {16'd0, r_delay};
    assign w_window_done = w_el_entry >= {16'd0, r_window};
    assign w_blink_due   = w_el_blink >= {16'd0, r_period};

    always_comb begin
        n_state    = r_state;
        n_entry    = r_entry;
        n_blink    = r_blink;
        n_level    = r_level;
        n_led      = 1'b0;
        n_pulse    = 1'b0;
        n_event    = lsr_pkg::EV_NONE;
        w_lvl      = r_level;
        case (r_state)
            lsr_pkg::ST_ONLINE: begin
                n_led = 1'b1;
                if (!w_ready_link) begin
                    n_state = lsr_pkg::ST_OFFLINE;
                    n_entry = i_poll.now_ms;
                    n_led   = 1'b0;
                    n_event = lsr_pkg::EV_OFFLINE;
                end
            end
            lsr_pkg::ST_OFFLINE: begin
                if (w_ready_link) begin
                    n_state = lsr_pkg::ST_ONLINE;
                    n_entry = i_poll.now_ms;
                    n_led   = 1'b1;
                    n_event = lsr_pkg::EV_ONLINE;
                end else if (w_delay_done) begin
                    n_state = lsr_pkg::ST_RECONN;
                    n_entry = i_poll.now_ms;
                    n_blink = i_poll.now_ms;
                    n_level = 1'b1;
                    n_led   = 1'b1;
                    n_pulse = 1'b1;
                    n_event = lsr_pkg::EV_RECOVERY;
                end
            end
            lsr_pkg::ST_RECONN: begin
                if (w_ready_link) begin
                    n_state = lsr_pkg::ST_ONLINE;
                    n_entry = i_poll.now_ms;
                    n_led   = 1'b1;
                    n_event = lsr_pkg::EV_ONLINE;
                end else begin
                    if (w_blink_due) begin
                        n_blink = i_poll.now_ms;
                        w_lvl   = !r_level;
                    end
                    n_level = w_lvl;
                    n_led   = w_lvl;
                    if (w_window_done) begin
                        n_state = lsr_pkg::ST_OFFLINE;
                        n_entry = i_poll.now_ms;
                        n_level = 1'b0;
                        n_led   = 1'b0;
                    end
                end
            end
            default: begin
                n_state = lsr_pkg::ST_OFFLINE;
                n_entry = i_poll.now_ms;
            end
        endcase
    end

    always_comb begin
        case (n_state)
            lsr_pkg::ST_RECONN: n_mode_out = lsr_pkg::MODE_RECONN;
            lsr_pkg::ST_ONLINE: n_mode_out = lsr_pkg::MODE_ONLINE;
            default:            n_mode_out = lsr_pkg::MODE_OFFLINE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lsr_pkg::ST_OFFLINE;
            r_entry     <= '0;
            r_blink     <= '0;
            r_level     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_state <= n_state;
                r_entry <= n_entry;
                r_blink <= n_blink;
                r_level <= n_level;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_led      <= n_led;
            r_pulse    <= n_pulse;
            r_event    <= n_event;
            r_flags    <= {i_poll.address_set, i_poll.link_up, i_poll.interface_up,
                           i_poll.default_iface_present};
            r_mode_out <= n_mode_out;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.indicator_on    = r_led;
    assign o_result.phy_reset_pulse = r_pulse;
    assign o_result.event_code      = r_event;
    assign o_result.status_flags    = r_flags;
    assign o_result.link_mode       = r_mode_out;

endmodule

>>> hw/rtl/lsr_checker.sv
// ----------------------------------------------------------------------------
// Link supervisor checker
// Port-level checks on the result channel of the link supervisor.
// ----------------------------------------------------------------------------
module lsr_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_ready,
    input  logic                  i_led,
    input  logic                  i_pulse,
    input  lsr_pkg::t_event       i_event,
    input  logic [3:0]            i_flags,
    input  lsr_pkg::t_mode_code   i_mode
);

    a_pulse_starts_recovery: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_pulse |-> i_event == lsr_pkg::EV_RECOVERY
                               && i_mode == lsr_pkg::MODE_RECONN && i_led)
        else $error("reset pulse without recovery start");

    a_online_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_mode == lsr_pkg::MODE_ONLINE |-> i_led && !i_pulse)
        else $error("online with dark indicator");

    a_event_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && (i_event == lsr_pkg::EV_OFFLINE || i_event == lsr_pkg::EV_ONLINE)
        |-> i_mode == i_event - 2'd1 + i_event[1] && !i_pulse)
        else $error("event code disagrees with mode");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_led) && $stable(i_pulse)
                                && $stable(i_event) && $stable(i_flags) && $stable(i_mode))
        else $error("stalled result changed");

endmodule

bind link_supervisor_with_recovery lsr_checker u_lsr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (o_result.valid),
    .i_ready (o_result.ready),
    .i_led   (o_result.indicator_on),
    .i_pulse (o_result.phy_reset_pulse),
    .i_event (o_result.event_code),
    .i_flags (o_result.status_flags),
    .i_mode  (o_result.link_mode)
);
